// ----- hdl/b64sc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_pkg
// Shared types, constants and alphabet functions for the Base64 stream codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

	// result bytes one input can cause
	localparam int unsigned JOB_MAX     = 4;
	localparam int unsigned JOB_CNT_W   = 3;
	localparam int unsigned QUEUE_DEPTH = 2;

	// configuration port
	localparam int unsigned CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DECODE_MODE  = 2'd0,
		CFG_URL_ALPHABET = 2'd1,
		CFG_PAD_OUTPUT   = 2'd2
	} cfg_idx_t;

	// alphabet characters
	localparam logic [7:0] CHAR_PAD    = 8'h3D;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_SLASH  = 8'h2F;
	localparam logic [7:0] CHAR_DASH   = 8'h2D;
	localparam logic [7:0] CHAR_USCORE = 8'h5F;
	localparam logic [7:0] CHAR_UP_A   = 8'h41;
	localparam logic [7:0] CHAR_UP_Z   = 8'h5A;
	localparam logic [7:0] CHAR_LO_A   = 8'h61;
	localparam logic [7:0] CHAR_LO_Z   = 8'h7A;
	localparam logic [7:0] CHAR_DIG_0  = 8'h30;
	localparam logic [7:0] CHAR_DIG_9  = 8'h39;

	// symbol code with skip flag in the top bit
	localparam logic [6:0] SYM_SKIP = 7'd64;

	// result bytes of one input, first byte in slot 0
	typedef struct packed {
		logic [JOB_MAX-1:0][7:0] bytes;
		logic [JOB_CNT_W-1:0]    count;
	} job_t;

	// 6-bit value to alphabet character
	function automatic logic [7:0] sym_to_char(input logic [5:0] v, input logic url);
		logic [7:0] c;
		if (v < 6'd26) begin
			c = CHAR_UP_A + {2'b00, v};
		end else if (v < 6'd52) begin
			c = CHAR_LO_A + {2'b00, v} - 8'd26;
		end else if (v < 6'd62) begin
			c = CHAR_DIG_0 + {2'b00, v} - 8'd52;
		end else if (v == 6'd62) begin
			c = url ? CHAR_DASH : CHAR_PLUS;
		end else begin
			c = url ? CHAR_USCORE : CHAR_SLASH;
		end
		return c;
	endfunction

	// character to symbol, both alphabets; bit 6 set means skip
	function automatic logic [6:0] char_to_sym(input logic [7:0] c);
		logic [6:0] s;
		logic [7:0] t;
		s = SYM_SKIP;
		t = 8'd0;
		if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
			t = c - CHAR_UP_A;
			s = t[6:0];
		end else if (c >= CHAR_LO_A && c <= CHAR_LO_Z) begin
			t = c - CHAR_LO_A + 8'd26;
			s = t[6:0];
		end else if (c >= CHAR_DIG_0 && c <= CHAR_DIG_9) begin
			t = c - CHAR_DIG_0 + 8'd52;
			s = t[6:0];
		end else if (c == CHAR_PLUS || c == CHAR_DASH) begin
			s = 7'd62;
		end else if (c == CHAR_SLASH || c == CHAR_USCORE) begin
			s = 7'd63;
		end
		return s;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/b64sc_item_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_item_if
// Input channel: one data byte or end-of-stream marker per transaction.
// ----------------------------------------------------------------------------
interface b64sc_item_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;

	modport source (output valid, output kind, output data_byte, input ready);
	modport sink   (input valid, input kind, input data_byte, output ready);
endinterface
`default_nettype wire

// ----- hdl/b64sc_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_result_if
// Output channel: one encoded character or decoded byte per transaction.
// ----------------------------------------------------------------------------
interface b64sc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       last;

	modport source (output valid, output out_byte, output last, input ready);
	modport sink   (input valid, input out_byte, input last, output ready);
endinterface
`default_nettype wire

// ----- hdl/b64sc_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface b64sc_cfg_if;
	logic                               valid;
	logic                               ready;
	logic [b64sc_pkg::CFG_IDX_W-1:0]    addr;
	logic                               data;

	modport source (output valid, output addr, output data, input ready);
	modport sink   (input valid, input addr, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/b64sc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_front
// Accepts input transactions, keeps the pending group and the settings, and
// turns each completed group or flush into a job of result bytes.
// ----------------------------------------------------------------------------
module b64sc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	b64sc_item_if.sink            item,
	b64sc_cfg_if.sink             cfg,
	input  wire logic             q_full,
	output      logic             q_push,
	output      b64sc_pkg::job_t  q_data
);

	logic       decode_mode_q;
	logic       url_alphabet_q;
	logic       pad_output_q;
	logic [1:0] phase_q;
	logic [7:0] elem_q [4];

	logic            accept;
	logic            cfg_wr;
	logic [6:0]      sym;
	logic [7:0]      e0, e1, e2;
	logic [7:0]      part;
	logic [1:0]      phase_d;
	logic            elem_we;
	logic [7:0]      elem_wdata;
	b64sc_pkg::job_t job_d;

	assign item.ready = !q_full;
	assign cfg.ready  = 1'b1;
	assign accept     = item.valid && item.ready;
	assign cfg_wr     = cfg.valid && cfg.ready;

	assign sym = b64sc_pkg::char_to_sym(item.data_byte);
	assign e0  = elem_q[0];
	assign e1  = elem_q[1];
	assign e2  = elem_q[2];

	// classify the transaction and build its job
	always_comb begin
		job_d      = '0;
		phase_d    = phase_q;
		elem_we    = 1'b0;
		elem_wdata = item.data_byte;
		part       = 8'd0;
		if (accept) begin
			if (!item.kind) begin
				if (decode_mode_q) begin
					// decode: collect four symbols, skip everything else
					if (!sym[6]) begin
						elem_wdata = {2'b00, sym[5:0]};
						if (phase_q != 2'd3) begin
							elem_we = 1'b1;
							phase_d = phase_q + 2'd1;
						end else begin
							job_d.bytes[0] = {e0[5:0], e1[5:4]};
							job_d.bytes[1] = {e1[3:0], e2[5:2]};
							job_d.bytes[2] = {e2[1:0], sym[5:0]};
							job_d.count    = 3'd3;
							phase_d        = 2'd0;
						end
					end
				end else begin
					// encode: collect three bytes
					if (phase_q < 2'd2) begin
						elem_we = 1'b1;
						phase_d = phase_q + 2'd1;
					end else begin
						job_d.bytes[0] = b64sc_pkg::sym_to_char(e0[7:2], url_alphabet_q);
						job_d.bytes[1] = b64sc_pkg::sym_to_char({e0[1:0], e1[7:4]},
							url_alphabet_q);
						job_d.bytes[2] = b64sc_pkg::sym_to_char({e1[3:0], item.data_byte[7:6]},
							url_alphabet_q);
						job_d.bytes[3] = b64sc_pkg::sym_to_char(item.data_byte[5:0],
							url_alphabet_q);
						job_d.count    = 3'd4;
						phase_d        = 2'd0;
					end
				end
			end else begin
				// end of stream: drain the partial group
				phase_d = 2'd0;
				if (decode_mode_q) begin
					unique case (phase_q)
						2'd1: begin
							part           = {e0[5:0], 2'b00};
							job_d.bytes[0] = part;
							job_d.count    = (part != 8'd0) ? 3'd1 : 3'd0;
						end
						2'd2: begin
							part           = {e1[3:0], 4'b0000};
							job_d.bytes[0] = {e0[5:0], e1[5:4]};
							job_d.bytes[1] = part;
							job_d.count    = (part != 8'd0) ? 3'd2 : 3'd1;
						end
						2'd3: begin
							part           = {e2[1:0], 6'b000000};
							job_d.bytes[0] = {e0[5:0], e1[5:4]};
							job_d.bytes[1] = {e1[3:0], e2[5:2]};
							job_d.bytes[2] = part;
							job_d.count    = (part != 8'd0) ? 3'd3 : 3'd2;
						end
						default: begin
							job_d.count = 3'd0;
						end
					endcase
				end else begin
					unique case (phase_q)
						2'd1: begin
							job_d.bytes[0] = b64sc_pkg::sym_to_char(e0[7:2], url_alphabet_q);
							job_d.bytes[1] = b64sc_pkg::sym_to_char({e0[1:0], 4'b0000},
								url_alphabet_q);
							job_d.bytes[2] = b64sc_pkg::CHAR_PAD;
							job_d.bytes[3] = b64sc_pkg::CHAR_PAD;
							job_d.count    = pad_output_q ? 3'd4 : 3'd2;
						end
						2'd2: begin
							job_d.bytes[0] = b64sc_pkg::sym_to_char(e0[7:2], url_alphabet_q);
							job_d.bytes[1] = b64sc_pkg::sym_to_char({e0[1:0], e1[7:4]},
								url_alphabet_q);
							job_d.bytes[2] = b64sc_pkg::sym_to_char({e1[3:0], 2'b00},
								url_alphabet_q);
							job_d.bytes[3] = b64sc_pkg::CHAR_PAD;
							job_d.count    = pad_output_q ? 3'd4 : 3'd3;
						end
						default: begin
							job_d.count = 3'd0;
						end
					endcase
				end
			end
		end
	end

	assign q_push = accept && (job_d.count != 3'd0);
	assign q_data = job_d;

	// settings and group phase; a mode write clears the group
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decode_mode_q  <= 1'b0;
			url_alphabet_q <= 1'b0;
			pad_output_q   <= 1'b0;
			phase_q        <= 2'd0;
		end else begin
			phase_q <= phase_d;
			if (cfg_wr) begin
				unique case (cfg.addr)
					b64sc_pkg::CFG_DECODE_MODE: begin
						decode_mode_q <= cfg.data;
						phase_q       <= 2'd0;
					end
					b64sc_pkg::CFG_URL_ALPHABET: url_alphabet_q <= cfg.data;
					b64sc_pkg::CFG_PAD_OUTPUT:   pad_output_q   <= cfg.data;
					default: ;
				endcase
			end
		end
	end

	// pending group elements
	always_ff @(posedge clk) begin
		if (elem_we) begin
			elem_q[phase_q] <= elem_wdata;
		end
	end

	// a third encode byte always completes a group
	a_enc_group: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !item.kind && !decode_mode_q && phase_q == 2'd2) |-> q_push)
		else $error("encode group did not produce a job");

	// the encoder never holds more than two pending bytes
	a_enc_phase: assert property (@(posedge clk) disable iff (!arst_n)
		!decode_mode_q |-> (phase_q != 2'd3))
		else $error("encoder phase out of range");

endmodule
`default_nettype wire

// ----- hdl/b64sc_fifo.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_fifo
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module b64sc_fifo #(
	parameter int unsigned DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire b64sc_pkg::job_t  push_data,
	output      logic             full,
	input  wire logic             pop,
	output      logic             not_empty,
	output      b64sc_pkg::job_t  pop_data
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	b64sc_pkg::job_t    mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   cnt_q;

	assign full      = (cnt_q == CNT_FULL);
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("job queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty)
		else $error("job queue underflow");

endmodule
`default_nettype wire

// ----- hdl/b64sc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// b64sc_back
// Takes jobs from the queue and sends their bytes through the output register,
// one per cycle while the output is ready, marking the final byte of each job.
// ----------------------------------------------------------------------------
module b64sc_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire b64sc_pkg::job_t  q_data,
	output      logic             q_pop,
	b64sc_result_if.source        result
);

	b64sc_pkg::job_t job_q;
	logic            busy_q;
	logic [1:0]      idx_q;
	logic            out_valid_q;
	logic [7:0]      out_byte_q;
	logic            out_last_q;

	logic            adv;
	logic            fin;
	logic [1:0]      cnt_m1;

	// index of the final byte; a count of four wraps to three
	assign cnt_m1 = job_q.count[1:0] - 2'd1;
	assign adv    = busy_q && (!out_valid_q || result.ready);
	assign fin    = adv && (idx_q == cnt_m1);
	assign q_pop  = q_valid && (!busy_q || fin);

	assign result.valid    = out_valid_q;
	assign result.out_byte = out_byte_q;
	assign result.last     = out_last_q;

	// job holder and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= 2'd0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
				idx_q  <= 2'd0;
			end else if (fin) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				idx_q <= idx_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_data;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_byte_q <= job_q.bytes[idx_q];
			out_last_q <= fin;
		end
	end

	a_job_count: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (job_q.count != 3'd0 && job_q.count <= 3'd4))
		else $error("job with bad byte count");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> ({1'b0, idx_q} < job_q.count))
		else $error("byte index past end of job");

endmodule
`default_nettype wire

// ----- hdl/base64_stream_codec_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// base64_stream_codec_unit
// Streaming Base64 encoder and decoder, standard and URL-safe alphabets.
// ----------------------------------------------------------------------------
// The block takes an input transaction in every cycle while its job queue has
// room; each transaction is classified at once and any results it causes go
// into the queue as one job of one to four bytes. The back end sends one
// result per cycle while the output is ready, so the output rate sets the
// sustained pace; a decoder stream keeps up at one input per cycle. The first
// result of a transaction is registered in the job queue, then in the job
// holder, then in the output register after the transaction is accepted.
// Configuration writes are taken in any cycle and must come while idle;
// writing the decode mode drops any partial group.
// ----------------------------------------------------------------------------
module base64_stream_codec_unit #(
	parameter int unsigned QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	b64sc_item_if.sink       item,
	b64sc_result_if.source   result,
	b64sc_cfg_if.sink        cfg
);

	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_valid;
	b64sc_pkg::job_t q_wdata;
	b64sc_pkg::job_t q_rdata;

	// accept, classify and group
	b64sc_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cfg    (cfg),
		.q_full (q_full),
		.q_push (q_push),
		.q_data (q_wdata)
	);

	// job queue
	b64sc_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_valid),
		.pop_data  (q_rdata)
	);

	// serialize results
	b64sc_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_data  (q_rdata),
		.q_pop   (q_pop),
		.result  (result)
	);

endmodule
`default_nettype wire
